>>> hw/rtl/rfes_pkg.sv
`default_nettype none

package rfes_pkg;

	localparam int MAX_SLOT_COUNT_DEF = 256;

	localparam logic [31:0] OBJ_MAGIC = 32'h4E58534F;
	localparam logic [7:0]  CONT_BIT  = 8'h80;
	localparam logic [7:0]  BITS_MASK = 8'h7F;
	localparam logic [16:0] POS_MAX   = 17'h1FFFF;

	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_LENGTH,
		PH_MASK,
		PH_SKIPMASK,
		PH_TABLE,
		PH_VALUE,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		LK_UNDECIDED,
		LK_PRESENT,
		LK_ABSENT,
		LK_BEHIND
	} lookup_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_MAGIC = 3'd1,
		ST_ABSENT    = 3'd2,
		ST_TRUNCATED = 3'd3,
		ST_BEHIND    = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       first_of_batch;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic [15:0]        field_offset;
		logic signed [63:0] field_value;
		logic signed [63:0] running_sum;
	} result_t;

	// expected magic byte at a given position of the first word
	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0: r = OBJ_MAGIC[7:0];
			2'd1: r = OBJ_MAGIC[15:8];
			2'd2: r = OBJ_MAGIC[23:16];
			2'd3: r = OBJ_MAGIC[31:24];
			default: r = OBJ_MAGIC[7:0];
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rfes_in_stage.sv
`default_nettype none

module rfes_in_stage
	import rfes_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire item_t      item_in,
	input  wire logic       step,
	output logic            valid_s1,
	output item_t           item_s1
);

	// register frees up in the same cycle its item moves on
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_in;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/rfes_parse.sv
`default_nettype none

module rfes_parse
	import rfes_pkg::*;
#(
	parameter int MAX_SLOT_COUNT = MAX_SLOT_COUNT_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       step,
	input  wire item_t      item_s1,
	output result_t         res
);

	logic [7:0]  slot_q;
	logic [16:0] pos_q, pos_n;
	logic        magic_q, magic_n;
	logic [8:0]  sc_q, sc_n;
	logic [8:0]  ti_q, ti_n;
	phase_t      phase_q, phase_n;
	lookup_t     lk_q, lk_n;
	logic [16:0] ts_q, ts_n;
	logic [15:0] ro_q, ro_n;
	logic [63:0] val_q, val_n;
	logic [63:0] sum_q, sum_n, sum_base;

	logic [7:0]  b;
	logic [6:0]  bits;
	logic [8:0]  slot_gap;
	logic [2:0]  lim;
	logic [2:0]  cnt;
	logic        found;
	logic [17:0] pos18, ot, ro18;
	logic [2:0]  k;
	logic [31:0] slot_w;
	status_t     st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (cfg_we) begin
			slot_q <= cfg_wdata;
		end
	end

	always_comb begin
		b        = item_s1.data_byte;
		bits     = b[6:0] & BITS_MASK[6:0];
		pos18    = {1'b0, pos_q};
		slot_w   = 32'(slot_q);
		slot_gap = {1'b0, slot_q} - sc_q;
		found    = slot_gap < 9'd7;
		lim      = found ? slot_gap[2:0] : 3'd7;
		ot       = {1'b0, ts_q} + {8'b0, ti_q, 1'b0};
		ro18     = {2'b0, ro_q};
		k        = 3'(pos18 - ro18);
		cnt      = '0;
		// set bits of slots below the configured one
		for (int i = 0; i < 7; i++) begin
			if (3'(i) < lim && bits[i]) begin
				cnt = cnt + 3'd1;
			end
		end

		pos_n   = pos_q;
		magic_n = magic_q;
		sc_n    = sc_q;
		ti_n    = ti_q;
		phase_n = phase_q;
		lk_n    = lk_q;
		ts_n    = ts_q;
		ro_n    = ro_q;
		val_n   = val_q;

		if (pos_q != POS_MAX) begin
			pos_n = pos_q + 17'd1;
			case (phase_q)
				PH_MAGIC: begin
					if (b != magic_byte(pos_q[1:0])) begin
						magic_n = 1'b0;
					end
					if (pos_q >= 17'd3) begin
						phase_n = PH_LENGTH;
					end
				end
				PH_LENGTH: begin
					if (pos_q >= 17'd7) begin
						if (!magic_q) begin
							phase_n = PH_DONE;
						end else if (slot_w >= 32'(MAX_SLOT_COUNT)) begin
							lk_n    = LK_ABSENT;
							phase_n = PH_DONE;
						end else begin
							sc_n    = '0;
							ti_n    = '0;
							phase_n = PH_MASK;
						end
					end
				end
				PH_MASK: begin
					ti_n = ti_q + {6'b0, cnt};
					if (found) begin
						if (!bits[lim]) begin
							lk_n    = LK_ABSENT;
							phase_n = PH_DONE;
						end else begin
							lk_n = LK_PRESENT;
							if ((b & CONT_BIT) != 8'd0) begin
								phase_n = PH_SKIPMASK;
							end else begin
								ts_n    = pos_q + 17'd1;
								phase_n = PH_TABLE;
							end
						end
					end else begin
						sc_n = sc_q + 9'd7;
						if ((b & CONT_BIT) == 8'd0) begin
							lk_n    = LK_ABSENT;
							phase_n = PH_DONE;
						end
					end
				end
				PH_SKIPMASK: begin
					if ((b & CONT_BIT) == 8'd0) begin
						ts_n    = pos_q + 17'd1;
						phase_n = PH_TABLE;
					end
				end
				PH_TABLE: begin
					if (pos18 == ot) begin
						ro_n = {8'b0, b};
					end else if (pos18 == ot + 18'd1) begin
						ro_n = {b, ro_q[7:0]};
						if ({2'b0, ro_n} < pos18 + 18'd1) begin
							lk_n    = LK_BEHIND;
							phase_n = PH_DONE;
						end else begin
							phase_n = PH_VALUE;
						end
					end
				end
				PH_VALUE: begin
					if (pos18 >= ro18 && pos18 <= ro18 + 18'd7) begin
						val_n = val_q | ({56'b0, b} << {k, 3'b000});
						if (k == 3'd7) begin
							phase_n = PH_DONE;
						end
					end
				end
				default: begin
				end
			endcase
		end

		if (pos_q < 17'd7) begin
			st = ST_TRUNCATED;
		end else if (!magic_n) begin
			st = ST_BAD_MAGIC;
		end else if (lk_n == LK_ABSENT) begin
			st = ST_ABSENT;
		end else if (lk_n == LK_BEHIND) begin
			st = ST_BEHIND;
		end else if (lk_n == LK_PRESENT && phase_n == PH_DONE) begin
			st = ST_OK;
		end else begin
			st = ST_TRUNCATED;
		end

		// batch flag only counts on a record's first byte
		sum_base = (pos_q == 17'd0 && item_s1.first_of_batch) ? 64'd0 : sum_q;
		sum_n    = sum_base;
		if (item_s1.last_byte && st == ST_OK) begin
			sum_n = sum_base + val_n;
		end

		res.status       = st;
		res.field_offset = (st == ST_OK || st == ST_BEHIND) ? ro_n : 16'd0;
		res.field_value  = (st == ST_OK) ? val_n : 64'd0;
		res.running_sum  = sum_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			magic_q <= 1'b1;
			sc_q    <= '0;
			ti_q    <= '0;
			phase_q <= PH_MAGIC;
			lk_q    <= LK_UNDECIDED;
			ts_q    <= '0;
			ro_q    <= '0;
			val_q   <= '0;
			sum_q   <= '0;
		end else if (step) begin
			sum_q <= sum_n;
			if (item_s1.last_byte) begin
				pos_q   <= '0;
				magic_q <= 1'b1;
				sc_q    <= '0;
				ti_q    <= '0;
				phase_q <= PH_MAGIC;
				lk_q    <= LK_UNDECIDED;
				ts_q    <= '0;
				ro_q    <= '0;
				val_q   <= '0;
			end else begin
				pos_q   <= pos_n;
				magic_q <= magic_n;
				sc_q    <= sc_n;
				ti_q    <= ti_n;
				phase_q <= phase_n;
				lk_q    <= lk_n;
				ts_q    <= ts_n;
				ro_q    <= ro_n;
				val_q   <= val_n;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/rfes_out_stage.sv
`default_nettype none

module rfes_out_stage
	import rfes_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   load,
	input  wire result_t res,
	output logic        out_free,
	output logic        out_valid,
	input  wire logic   out_ready,
	output result_t     res_q
);

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/record_field_extract_sum_top.sv
// a record's last byte passes through the input register, and its result is then loaded into the result register
// throughput: one byte item per cycle, sustained, with a free-running output side
// per byte: one popcount over seven mask bits and a few compares between two registers
// reset (arst_n low, asynchronous): both stages empty, slot 0, running sum 0, parser at magic
`default_nettype none

module record_field_extract_sum_top
	import rfes_pkg::*;
#(
	parameter int MAX_SLOT_COUNT = MAX_SLOT_COUNT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// slot register
	input  wire logic               cfg_we,
	input  wire logic [7:0]         cfg_wdata,
	// byte items in
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         data_byte,
	input  wire logic               last_byte,
	input  wire logic               first_of_batch,
	// result items out
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic [15:0]             field_offset,
	output logic signed [63:0]      field_value,
	output logic signed [63:0]      running_sum
);

	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	logic    step;
	logic    out_free;
	result_t res;
	result_t res_q;

	assign item_in.data_byte      = data_byte;
	assign item_in.last_byte      = last_byte;
	assign item_in.first_of_batch = first_of_batch;

	// a byte in the input register moves on unless it is a last byte
	// and the result register is still holding an untaken item
	assign step = valid_s1 && (!item_s1.last_byte || out_free);

	// input register
	rfes_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item_in  (item_in),
		.step     (step),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// per-record parse state, lookup walk, value capture and running sum
	rfes_parse #(
		.MAX_SLOT_COUNT (MAX_SLOT_COUNT)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.item_s1   (item_s1),
		.res       (res)
	);

	// result register, loaded only by a last byte
	rfes_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && item_s1.last_byte),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign status       = res_q.status;
	assign field_offset = res_q.field_offset;
	assign field_value  = res_q.field_value;
	assign running_sum  = res_q.running_sum;

endmodule

`default_nettype wire
